FILE: design/aes_pkg.sv
`default_nettype none
package aes_pkg;

   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO = 1'b1;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } cmd_type;

   localparam byte_type SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic byte_type xtime(byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

endpackage
`default_nettype wire

FILE: design/aes_stream_if.sv
`default_nettype none
interface aes_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] hi;
   logic [63:0] lo;
   modport source (output valid, output hi, output lo, input ready);
   modport sink (input valid, input hi, input lo, output ready);
endinterface
`default_nettype wire

FILE: design/aes_ctrl.sv
`default_nettype none
module aes_ctrl #(
   parameter int ROUNDS = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output aes_pkg::cmd_type   cmd
);
   import aes_pkg::*;

   localparam int CNT_W = $clog2(ROUNDS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   round_ff, round_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               round_in = CNT_W'(1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cmd.last = (round_ff == CNT_W'(ROUNDS));
            round_in = round_ff + CNT_W'(1);
            if (cmd.last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/aes_datapath.sv
`default_nettype none
module aes_datapath (
   input  wire logic         clock,
   input  wire logic [63:0]  key_hi,
   input  wire logic [63:0]  key_lo,
   input  wire logic [63:0]  plain_hi,
   input  wire logic [63:0]  plain_lo,
   input  wire aes_pkg::cmd_type cmd,
   output logic [63:0]       cipher_hi,
   output logic [63:0]       cipher_lo
);
   import aes_pkg::*;

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   byte_type     rcon_ff, rcon_in;

   logic [127:0] sr, mc, rnd;
   logic [31:0]  w3r, tw;
   logic [127:0] nkey, key0;
   byte_type     s [16];
   byte_type     a0, a1, a2, a3, all;

   assign key0 = {key_hi, key_lo};

   // next round key from current
   always_comb begin
      w3r = {rkey_ff[23:0], rkey_ff[31:24]};
      tw = {SBOX[w3r[31:24]], SBOX[w3r[23:16]], SBOX[w3r[15:8]], SBOX[w3r[7:0]]}
           ^ {rcon_ff, 24'h0};
      nkey[127:96] = rkey_ff[127:96] ^ tw;
      nkey[95:64]  = rkey_ff[95:64] ^ nkey[127:96];
      nkey[63:32]  = rkey_ff[63:32] ^ nkey[95:64];
      nkey[31:0]   = rkey_ff[31:0] ^ nkey[63:32];
   end

   // sub bytes, shift rows, mix columns (not in last round), add round key; byte i at bits 127-8i
   always_comb begin
      for (int i = 0; i < 16; i++) s[i] = state_ff[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sr[127-8*(r+4*c) -: 8] = SBOX[s[r + 4*((c+r)%4)]];
      for (int c = 0; c < 4; c++) begin
         a0 = sr[127-8*(4*c) -: 8];
         a1 = sr[127-8*(4*c+1) -: 8];
         a2 = sr[127-8*(4*c+2) -: 8];
         a3 = sr[127-8*(4*c+3) -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         mc[127-8*(4*c) -: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
         mc[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         mc[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         mc[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      rnd = (cmd.last ? sr : mc) ^ nkey;
   end

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      if (cmd.load) begin
         state_in = {plain_hi, plain_lo} ^ key0;
         rkey_in  = key0;
         rcon_in  = 8'h01;
      end else if (cmd.step) begin
         state_in = rnd;
         rkey_in  = nkey;
         rcon_in  = xtime(rcon_ff);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
   end

   assign cipher_hi = state_ff[127:64];
   assign cipher_lo = state_ff[63:0];
endmodule
`default_nettype wire

FILE: design/aes128_block_encrypt_core.sv
// aes-128 block encryption core
// request channel carries a 128-bit plaintext as plain hi/lo halves, byte 0
// most significant; response channel returns the ciphertext the same way.
// key is written through the csr port: index 0 key_hi, index 1 key_lo,
// one write per enabled clock edge; the user must write the key only while
// no request is in flight, as the core itself does not enforce this.
// a request is taken when the core is idle; a load step fills the state
// with the initial key addition, then ROUNDS rounds (ten by default) run on
// a single shared round unit with on-the-fly key expansion.
// response valid rises once the last round is stored, and the core returns
// to idle only after the response is taken, so it takes no new request
// until the previous block's response has been handed off.
// while the receiver stalls the ciphertext holds and no new request is taken.
// synchronous reset returns the core to idle and clears the key to zero.
`default_nettype none
module aes128_block_encrypt_core #(
   parameter int ROUNDS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   aes_stream_if.sink       req,
   aes_stream_if.source     rsp,
   input  wire logic        csr_we,
   input  wire logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0] csr_wdata
);
   import aes_pkg::*;

   logic [63:0] key_hi_ff, key_lo_ff;
   cmd_type     cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HI: key_hi_ff <= csr_wdata;
            CSR_KEY_LO: key_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   aes_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd
   );

   aes_datapath u_dp (
      .clock,
      .key_hi(key_hi_ff), .key_lo(key_lo_ff),
      .plain_hi(req.hi), .plain_lo(req.lo),
      .cmd,
      .cipher_hi(rsp.hi), .cipher_lo(rsp.lo)
   );
endmodule
`default_nettype wire

FILE: design/aes_checker.sv
`default_nettype none
module aes_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_hi,
   input wire logic [63:0] rsp_lo
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hi) && $stable(rsp_lo))
      else $error("response changed under stall");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##11 rsp_valid)
      else $error("response latency wrong");
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("response too early");
endmodule

bind aes128_block_encrypt_core aes_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_hi(rsp.hi), .rsp_lo(rsp.lo)
);
`default_nettype wire
